>>> hw/rtl/epoch_seconds_to_calendar_top_macros.svh
// Assertion helpers shared by the RTL of the epoch-to-calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ESC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/esc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Sequencer states of the converter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_DIV_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } esc_state_e;

  localparam int unsigned SecsWidth    = 32;
  localparam int unsigned OutDataWidth = 48;

  // Divisors, each shifted left by the step counter during restoring division.
  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [31:0] SecsPerHour = 32'd3600;
  localparam logic [31:0] SecsPerMin  = 32'd60;
  localparam logic [31:0] DaysPerWeek = 32'd7;

  // Last step index of each division (quotient bits minus one).
  localparam logic [3:0] DayLastStep  = 4'd15;
  localparam logic [3:0] HourLastStep = 4'd4;
  localparam logic [3:0] MinLastStep  = 4'd5;
  localparam logic [3:0] WdayLastStep = 4'd12;

  localparam logic [11:0] EpochYear   = 12'd1970;
  localparam logic [15:0] EpochWday   = 16'd4;   // day zero was a Thursday
  localparam logic [3:0]  LastMonth   = 4'd11;   // December, counted from zero
  localparam logic [11:0] CenturyNoLeap = 12'd2100;

  // Leap test for the years the 32-bit input can reach (1970 to 2106): the
  // only century year in that span that is not a leap year is 2100.
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != CenturyNoLeap);
  endfunction

  // Days in a year.
  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  // Days in a month, months counted from zero.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/epoch_seconds_to_calendar_top.sv
// Channel   Dir  tdata fields (lowest bit first)
// s_axis    in   epoch_seconds[31:0]
// m_axis    out  year[11:0] month[15:12] day_of_month[20:16] hour[25:21]
//                minute[31:26] second[37:32] weekday[40:38], zero [47:41]
//
// The year loop subtracts the whole years since 1970 (0 to 136 of them)
// and the month loop the whole months of the final year (0 to 11). All of
// it runs through a single 33-bit subtract-and-compare unit, one step per
// cycle: three restoring divisions for the time of day, one for the
// weekday, then the year and month subtraction loops. s_axis_tready_o is
// high only while the sequencer is idle.
// A finished result waits in the output register; the next item may be taken
// meanwhile, and the sequencer stalls at the end until the result is taken.
// Reset is asynchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_seconds_to_calendar_top_macros.svh"

module epoch_seconds_to_calendar_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // epoch_seconds[31:0]
  input  wire logic [esc_pkg::SecsWidth-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // year[11:0] month[15:12] day_of_month[20:16] hour[25:21] minute[31:26]
  // second[37:32] weekday[40:38], zero [47:41]
  output logic [esc_pkg::OutDataWidth-1:0]       m_axis_tdata_o
);

  import esc_pkg::*;

  esc_state_e  state_q, state_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [2:0]  wd_q, wd_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  mon_q, mon_d;

  logic        out_valid_q, out_valid_d;
  logic [11:0] out_year_q, out_year_d;
  logic [3:0]  out_month_q, out_month_d;
  logic [4:0]  out_day_q, out_day_d;
  logic [4:0]  out_hour_q, out_hour_d;
  logic [5:0]  out_min_q, out_min_d;
  logic [5:0]  out_sec_q, out_sec_d;
  logic [2:0]  out_wd_q, out_wd_d;

  logic        in_fire;
  logic        out_free;
  logic        leap;
  logic [31:0] op_b;
  logic [32:0] diff;
  logic        ge;
  logic [15:0] quo_next;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign leap     = is_leap(year_q);

  // Shared unit: subtrahend selection, then one subtract that also compares.
  always_comb begin
    case (state_q)
      ST_DIV_DAY:  op_b = SecsPerDay << cnt_q;
      ST_DIV_HOUR: op_b = SecsPerHour << cnt_q;
      ST_DIV_MIN:  op_b = SecsPerMin << cnt_q;
      ST_DIV_WDAY: op_b = DaysPerWeek << cnt_q;
      ST_YEAR:     op_b = 32'(year_len(leap));
      ST_MONTH:    op_b = 32'(month_len(mon_q, leap));
      default:     op_b = '0;
    endcase
  end

  assign diff     = {1'b0, rem_q} - {1'b0, op_b};
  assign ge       = !diff[32];
  assign quo_next = {quo_q[14:0], ge};

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_DIV_DAY;
      ST_DIV_DAY:  if (cnt_q == '0) state_d = ST_DIV_HOUR;
      ST_DIV_HOUR: if (cnt_q == '0) state_d = ST_DIV_MIN;
      ST_DIV_MIN:  if (cnt_q == '0) state_d = ST_DIV_WDAY;
      ST_DIV_WDAY: if (cnt_q == '0) state_d = ST_YEAR;
      ST_YEAR:     if (!ge) state_d = ST_MONTH;
      ST_MONTH:    if (!(ge && (mon_q < LastMonth))) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath registers and result register, driven per state.
  always_comb begin
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    days_d      = days_q;
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    wd_d        = wd_q;
    year_d      = year_q;
    mon_d       = mon_q;
    out_valid_d = out_valid_q;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_hour_d  = out_hour_q;
    out_min_d   = out_min_q;
    out_sec_d   = out_sec_q;
    out_wd_d    = out_wd_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rem_d = s_axis_tdata_i;
          quo_d = '0;
          cnt_d = DayLastStep;
        end
      end
      // Seconds by 86400: quotient is the day count, remainder the time of day.
      ST_DIV_DAY: begin
        quo_d = quo_next;
        if (ge) rem_d = diff[31:0];
        if (cnt_q == '0) begin
          days_d = quo_next;
          quo_d  = '0;
          cnt_d  = HourLastStep;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_DIV_HOUR: begin
        quo_d = quo_next;
        if (ge) rem_d = diff[31:0];
        if (cnt_q == '0) begin
          hour_d = quo_next[4:0];
          quo_d  = '0;
          cnt_d  = MinLastStep;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      // Minutes; the final remainder is the second, then set up the weekday.
      ST_DIV_MIN: begin
        quo_d = quo_next;
        if (ge) rem_d = diff[31:0];
        if (cnt_q == '0) begin
          min_d = quo_next[5:0];
          sec_d = ge ? diff[5:0] : rem_q[5:0];
          rem_d = {16'b0, days_q + EpochWday};
          quo_d = '0;
          cnt_d = WdayLastStep;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      // Remainder by seven gives the weekday; the day count goes back in.
      ST_DIV_WDAY: begin
        if (ge) rem_d = diff[31:0];
        if (cnt_q == '0) begin
          wd_d   = ge ? diff[2:0] : rem_q[2:0];
          rem_d  = {16'b0, days_q};
          year_d = EpochYear;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem_d  = diff[31:0];
          year_d = year_q + 12'd1;
        end else begin
          mon_d = '0;
        end
      end
      ST_MONTH: begin
        if (ge && (mon_q < LastMonth)) begin
          rem_d = diff[31:0];
          mon_d = mon_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_year_d  = year_q;
          out_month_d = mon_q + 4'd1;
          out_day_d   = rem_q[4:0] + 5'd1;
          out_hour_d  = hour_q;
          out_min_d   = min_q;
          out_sec_d   = sec_q;
          out_wd_d    = (wd_q == 3'd0) ? 3'd7 : wd_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    days_q      <= days_d;
    hour_q      <= hour_d;
    min_q       <= min_d;
    sec_q       <= sec_d;
    wd_q        <= wd_d;
    year_q      <= year_d;
    mon_q       <= mon_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_hour_q  <= out_hour_d;
    out_min_q   <= out_min_d;
    out_sec_q   <= out_sec_d;
    out_wd_q    <= out_wd_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_wd_q, out_sec_q, out_min_q, out_hour_q,
                            out_day_q, out_month_q, out_year_q};

  // Checks on the sequencer and the result.
  `ESC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_fire, !s_axis_tready_o, "ready after accept")
  `ESC_ASSERT_IMPLIES(a_tod_range, clk_i, rst_ni,
    state_q == ST_DIV_HOUR, rem_q < SecsPerDay, "time of day out of range")
  `ESC_ASSERT_IMPLIES(a_year_range, clk_i, rst_ni,
    state_q == ST_YEAR, year_q <= 12'd2106, "year overrun")
  `ESC_ASSERT_IMPLIES(a_month_range, clk_i, rst_ni,
    state_q == ST_MONTH, mon_q <= LastMonth, "month overrun")
  `ESC_ASSERT_IMPLIES(a_result_from_done, clk_i, rst_ni,
    $rose(out_valid_q), $past(state_q == ST_DONE), "result not from done")
  `ESC_ASSERT_IMPLIES(a_result_fields, clk_i, rst_ni,
    out_valid_q,
    (out_month_q != 4'd0) && (out_day_q != 5'd0) && (out_wd_q != 3'd0),
    "result field zero")

endmodule

`default_nettype wire

>>> sim/epoch_seconds_to_calendar_top_checker.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  input  logic                                s_axis_tready_i,
  // epoch_seconds[31:0]
  input  logic [esc_pkg::SecsWidth-1:0]       s_axis_tdata_i,
  input  logic                                m_axis_tvalid_i,
  input  logic                                m_axis_tready_i,
  // year[11:0] month[15:12] day_of_month[20:16] hour[25:21] minute[31:26]
  // second[37:32] weekday[40:38], zero [47:41]
  input  logic [esc_pkg::OutDataWidth-1:0]    m_axis_tdata_i,
  output int                                  mismatch_count_o,
  output int                                  dates_owed_o
);

  // Result item as laid out on the output bus, highest bits first.
  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  weekday;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  typedef struct {
    logic [31:0] epoch;
    calendar_t   date;
  } owed_date_t;

  localparam int unsigned SECONDS_PER_DAY = 86400;
  localparam int unsigned FIRST_YEAR      = 1970;
  localparam int unsigned THURSDAY_SHIFT  = 4;
  localparam int unsigned DECEMBER        = 11;
  localparam int unsigned FEBRUARY        = 1;
  localparam int unsigned COMMON_MONTH_DAYS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  owed_date_t owed_dates[$];

  // Full Gregorian rule, independent of the range the input can reach.
  function automatic bit gregorian_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Calendar date and time of day for a count of seconds since the epoch.
  function automatic calendar_t calendar_of(input logic [31:0] epoch);
    int unsigned day_secs;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned wd;
    int unsigned span;
    calendar_t   c;
    day_secs = epoch % SECONDS_PER_DAY;
    days     = epoch / SECONDS_PER_DAY;
    wd       = (days + THURSDAY_SHIFT) % 7;
    yr       = FIRST_YEAR;
    span     = gregorian_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days = days - span;
      yr   = yr + 1;
      span = gregorian_leap(yr) ? 366 : 365;
    end
    mon  = 0;
    span = COMMON_MONTH_DAYS[0];
    while (mon < DECEMBER && days >= span) begin
      days = days - span;
      mon  = mon + 1;
      span = COMMON_MONTH_DAYS[mon] + ((mon == FEBRUARY && gregorian_leap(yr)) ? 1 : 0);
    end
    c.pad          = '0;
    c.year         = yr[11:0];
    c.month        = 4'(mon + 1);
    c.day_of_month = 5'(days + 1);
    c.hour         = 5'(day_secs / 3600);
    c.minute       = 6'((day_secs % 3600) / 60);
    c.second       = 6'(day_secs % 60);
    c.weekday      = (wd == 0) ? 3'd7 : 3'(wd);
    return c;
  endfunction

  task automatic report_field(input string field, input logic [31:0] epoch,
                              input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $display("%0t: epoch %0d, %s expected %0d, got %0d", $time, epoch, field, want, seen);
      mismatch_count_o++;
    end
  endtask

  // Results are checked before new items are logged, so an item taken in the
  // same cycle can never satisfy a result.
  always @(posedge clk_i) begin
    owed_date_t owed;
    calendar_t  seen;
    owed_date_t fresh;
    if (!rst_ni) begin
      owed_dates.delete();
      mismatch_count_o = 0;
      dates_owed_o     = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen = m_axis_tdata_i;
        if (owed_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata_i);
          mismatch_count_o++;
        end else begin
          owed = owed_dates.pop_front();
          report_field("year", owed.epoch, owed.date.year, seen.year);
          report_field("month", owed.epoch, owed.date.month, seen.month);
          report_field("day_of_month", owed.epoch, owed.date.day_of_month, seen.day_of_month);
          report_field("hour", owed.epoch, owed.date.hour, seen.hour);
          report_field("minute", owed.epoch, owed.date.minute, seen.minute);
          report_field("second", owed.epoch, owed.date.second, seen.second);
          report_field("weekday", owed.epoch, owed.date.weekday, seen.weekday);
          report_field("padding", owed.epoch, owed.date.pad, seen.pad);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fresh.epoch = s_axis_tdata_i;
        fresh.date  = calendar_of(s_axis_tdata_i);
        owed_dates.push_back(fresh);
      end
      dates_owed_o = owed_dates.size();
    end
  end

endmodule

>>> sim/epoch_seconds_to_calendar_top_test.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top_test;

  localparam int unsigned ITEMS_PER_PHASE = 457;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned PHASE_COUNT     = 4;

  // Edges of the day, the year, leap days, century years and the input range.
  localparam logic [31:0] BOUNDARY_EPOCHS [21] = '{
    32'd0,          32'd86399,      32'd86400,      32'd31535999,
    32'd31536000,   32'd68169600,   32'd94694399,   32'd946684799,
    32'd946684800,  32'd951782400,  32'd951868799,  32'd978307199,
    32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
    32'd4133980799, 32'd4294943999, 32'd4294944000, 32'hAAAA_AAAA,
    32'hFFFF_FFFF
  };

  // Per phase: no idling, sender idle, receiver stalling, both.
  localparam int unsigned SENDER_IDLE_PCT [PHASE_COUNT]   = '{0, 47, 0, 31};
  localparam int unsigned RECEIVER_STALL_PCT [PHASE_COUNT] = '{0, 0, 47, 31};

  logic                               clk;
  logic                               rst_n;
  logic                               s_valid;
  logic                               s_ready;
  logic [esc_pkg::SecsWidth-1:0]      s_data;
  logic                               m_valid;
  logic                               m_ready;
  logic [esc_pkg::OutDataWidth-1:0]   m_data;
  int                                 mismatch_count;
  int                                 dates_owed;
  int unsigned                        sender_idle_pct;
  int unsigned                        receiver_stall_pct;

  epoch_seconds_to_calendar_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  epoch_seconds_to_calendar_top_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .mismatch_count_o (mismatch_count),
    .dates_owed_o     (dates_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random according to the current phase.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      m_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Offers one item after a random idle stretch and holds it until taken.
  task automatic send_epoch(input logic [31:0] epoch);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_data  = epoch;
    do @(posedge clk); while (!s_ready);
  endtask

  // Lets every outstanding result come back before going on.
  task automatic wait_for_dates;
    @(negedge clk);
    s_valid = 1'b0;
    wait (dates_owed == 0);
  endtask

  initial begin
    logic [31:0] epoch;
    longint      stamp;
    int unsigned kind;
    s_valid            = 1'b0;
    s_data             = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_n              = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      sender_idle_pct    = SENDER_IDLE_PCT[phase];
      receiver_stall_pct = RECEIVER_STALL_PCT[phase];
      if (phase == 0) begin
        foreach (BOUNDARY_EPOCHS[i]) send_epoch(BOUNDARY_EPOCHS[i]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          epoch = $urandom;
        end else if (kind < 8) begin
          // Day boundaries, where month and year rollovers live.
          stamp = longint'($urandom_range(0, 49710)) * 86400;
          case ($urandom_range(0, 2))
            0:       stamp = stamp + 86399;
            1:       stamp = stamp + $urandom_range(0, 86399);
            default: stamp = stamp;
          endcase
          epoch = (stamp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stamp[31:0];
        end else if (kind == 8) begin
          epoch = $urandom_range(0, 200000000);
        end else begin
          epoch = 32'hFFFF_FFFF - $urandom_range(0, 200000000);
        end
        send_epoch(epoch);
      end
      wait_for_dates();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("epoch_seconds_to_calendar_top verification clean");
    end else begin
      $display("epoch_seconds_to_calendar_top verification failed");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #50_000_000;
    $display("epoch_seconds_to_calendar_top verification failed");
    $finish;
  end

endmodule
